// File: design/lrsc_pkg.sv
`timescale 1ns / 1ps

package lrsc_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned FIXED_BYTES = 17;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;
  localparam logic [7:0] PUT_TYPE_RST = 8'd0;
  localparam logic [7:0] DEL_TYPE_RST = 8'd1;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_MAX_PAYLOAD = 2'd0,
    CFG_PUT_TYPE    = 2'd1,
    CFG_DEL_TYPE    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_END      = 3'd1,
    ST_OVERSIZE = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_SHORT    = 3'd4,
    ST_BAD_TYPE = 3'd5,
    ST_MISMATCH = 3'd6
  } status_t;

  typedef struct packed {
    logic [31:0] max_payload;
    logic [7:0]  put_type;
    logic [7:0]  del_type;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        is_delete;
    logic [63:0] seq;
    logic [31:0] klen;
    logic [31:0] vlen;
    status_t     status;
    logic        last;
  } result_t;

endpackage

// File: design/lrsc_cfg_regs.sv
`timescale 1ns / 1ps

module lrsc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output lrsc_pkg::cfg_t     cfg
);
  import lrsc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
      cfg_r.put_type    <= PUT_TYPE_RST;
      cfg_r.del_type    <= DEL_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_data;
        CFG_PUT_TYPE:    cfg_r.put_type    <= cfg_data[7:0];
        CFG_DEL_TYPE:    cfg_r.del_type    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/lrsc_core.sv
`timescale 1ns / 1ps

module lrsc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [1:0]        cmd,
  input  logic [7:0]        data_byte,
  input  lrsc_pkg::cfg_t    cfg,
  output logic [1:0]        push_cnt,
  output lrsc_pkg::result_t push0,
  output lrsc_pkg::result_t push1
);
  import lrsc_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);
  localparam logic [31:0] FIXED_LEN = 32'(FIXED_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] pay_len_r, pay_len_nxt;
  logic [31:0] exp_sum_r, exp_sum_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] pay_cnt_r, pay_cnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] val_r, val_nxt;
  logic        fv_r, fv_nxt;

  logic        is_start, is_end, is_hdr, is_pay;
  logic        hdr_done, oversize, pay_end, data_go, verdict_go;
  kind_t       data_kind;
  status_t     v_st;
  result_t     data_res, verdict_res, stop_res;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'h0, b};
    return x * FNV_PRIME;
  endfunction

  function automatic logic type_ok(input logic [7:0] t, input cfg_t c);
    return (t == c.put_type) || (t == c.del_type);
  endfunction

  function automatic logic len_ok(input logic [31:0] k, input logic [31:0] v,
                                  input logic [31:0] len);
    logic [33:0] total;
    total = 34'(FIXED_LEN) + 34'(k) + 34'(v);
    return total == 34'(len);
  endfunction

  assign is_start = take && (cmd == CMD_START);
  assign is_end   = take && (cmd == CMD_END) && (phase_r != PH_STOPPED);
  assign is_hdr   = take && (cmd == CMD_DATA) && (phase_r == PH_HEADER);
  assign is_pay   = take && (cmd == CMD_DATA) && (phase_r == PH_PAYLOAD);
  assign hdr_done = (hdr_cnt_r == HDR_LAST);
  assign oversize = pay_len_r > cfg.max_payload;
  assign pay_end  = (33'(pay_cnt_r) + 33'd1) == 33'(pay_len_r);
  assign data_go  = is_pay && fv_r && (pay_cnt_r >= FIXED_LEN);
  assign data_kind = ((pay_cnt_r - FIXED_LEN) < key_r) ? KIND_KEY : KIND_VALUE;

  // an empty payload gets its verdict right at the last header byte
  assign verdict_go = (is_hdr && hdr_done && !oversize && (pay_len_r == 32'd0)) ||
                      (is_pay && pay_end);

  // record registers
  always_comb begin
    pay_len_nxt = pay_len_r;
    exp_sum_nxt = exp_sum_r;
    hash_nxt    = hash_r;
    pay_cnt_nxt = pay_cnt_r;
    type_nxt    = type_r;
    seq_nxt     = seq_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    fv_nxt      = fv_r;
    if (is_start) begin
      pay_len_nxt = '0;
      exp_sum_nxt = '0;
      hash_nxt    = FNV_BASIS;
      pay_cnt_nxt = '0;
      type_nxt    = '0;
      seq_nxt     = '0;
      key_nxt     = '0;
      val_nxt     = '0;
      fv_nxt      = 1'b0;
    end else if (is_hdr) begin
      if (!hdr_cnt_r[2]) begin
        if (hdr_cnt_r[1:0] == 2'd0) pay_len_nxt = {24'h0, data_byte};
        else pay_len_nxt[{hdr_cnt_r[1:0], 3'b000} +: 8] = data_byte;
      end else begin
        if (hdr_cnt_r[1:0] == 2'd0) exp_sum_nxt = {24'h0, data_byte};
        else exp_sum_nxt[{hdr_cnt_r[1:0], 3'b000} +: 8] = data_byte;
      end
      if (hdr_done && !oversize) begin
        hash_nxt    = FNV_BASIS;
        pay_cnt_nxt = '0;
        type_nxt    = '0;
        seq_nxt     = '0;
        key_nxt     = '0;
        val_nxt     = '0;
        fv_nxt      = 1'b0;
      end
    end else if (is_pay) begin
      hash_nxt    = fnv_step(hash_r, data_byte);
      pay_cnt_nxt = pay_cnt_r + 32'd1;
      if (pay_cnt_r == 32'd0) begin
        type_nxt = data_byte;
      end else if (pay_cnt_r <= 32'd8) begin
        seq_nxt[{3'(pay_cnt_r - 32'd1), 3'b000} +: 8] = data_byte;
      end else if (pay_cnt_r <= 32'd12) begin
        key_nxt[{2'(pay_cnt_r - 32'd9), 3'b000} +: 8] = data_byte;
      end else if (pay_cnt_r <= 32'd16) begin
        val_nxt[{2'(pay_cnt_r - 32'd13), 3'b000} +: 8] = data_byte;
        if (pay_cnt_r == 32'd16) fv_nxt = type_ok(type_r, cfg) && len_ok(key_nxt, val_nxt, pay_len_r);
      end
    end
  end

  // verdict priority: checksum, short payload, type, lengths
  always_comb begin
    priority if (hash_nxt != exp_sum_nxt)       v_st = ST_CHECKSUM;
    else if (pay_len_nxt < FIXED_LEN)           v_st = ST_SHORT;
    else if (!type_ok(type_nxt, cfg))           v_st = ST_BAD_TYPE;
    else if (!len_ok(key_nxt, val_nxt, pay_len_nxt)) v_st = ST_MISMATCH;
    else                                        v_st = ST_OK;
  end

  always_comb begin
    data_res      = '0;
    data_res.kind = data_kind;
    data_res.data = data_byte;
    data_res.last = !verdict_go;

    verdict_res = '0;
    verdict_res.last = 1'b1;
    if (v_st == ST_OK) begin
      verdict_res.kind      = KIND_ACCEPT;
      verdict_res.is_delete = (type_nxt != cfg.put_type);
      verdict_res.seq       = seq_nxt;
      verdict_res.klen      = key_nxt;
      verdict_res.vlen      = val_nxt;
      verdict_res.status    = ST_OK;
    end else begin
      verdict_res.kind   = KIND_STOP;
      verdict_res.status = v_st;
    end

    stop_res        = '0;
    stop_res.kind   = KIND_STOP;
    stop_res.last   = 1'b1;
    stop_res.status = oversize ? ST_OVERSIZE : ST_END;
  end

  // sequencing and result slots
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    push_cnt    = 2'd0;
    push0       = data_res;
    push1       = verdict_res;
    if (is_start) begin
      phase_nxt   = PH_HEADER;
      hdr_cnt_nxt = '0;
    end else if (is_end) begin
      phase_nxt   = PH_STOPPED;
      push_cnt    = 2'd1;
      push0       = stop_res;
      push0.status = ST_END;
    end else if (is_hdr) begin
      hdr_cnt_nxt = hdr_cnt_r + 3'd1;
      if (hdr_done) begin
        if (oversize) begin
          phase_nxt = PH_STOPPED;
          push_cnt  = 2'd1;
          push0     = stop_res;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end else if (is_pay) begin
      if (data_go) push_cnt = 2'd1;
    end
    if (verdict_go) begin
      phase_nxt = (v_st == ST_OK) ? PH_HEADER : PH_STOPPED;
      if (v_st == ST_OK) hdr_cnt_nxt = '0;
      if (data_go) begin
        push_cnt = 2'd2;
      end else begin
        push_cnt = 2'd1;
        push0    = verdict_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      pay_len_r <= '0;
      exp_sum_r <= '0;
      hash_r    <= FNV_BASIS;
      pay_cnt_r <= '0;
      type_r    <= '0;
      seq_r     <= '0;
      key_r     <= '0;
      val_r     <= '0;
      fv_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      pay_len_r <= pay_len_nxt;
      exp_sum_r <= exp_sum_nxt;
      hash_r    <= hash_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      type_r    <= type_nxt;
      seq_r     <= seq_nxt;
      key_r     <= key_nxt;
      val_r     <= val_nxt;
      fv_r      <= fv_nxt;
    end
  end

endmodule

// File: design/lrsc_res_fifo.sv
`timescale 1ns / 1ps

module lrsc_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  lrsc_pkg::result_t push0,
  input  lrsc_pkg::result_t push1,
  output logic              room,
  output logic              head_valid,
  input  logic              head_stall,
  output lrsc_pkg::result_t head,
  output logic [lrsc_pkg::RES_CNT_W-1:0] level
);
  import lrsc_pkg::*;

  result_t                mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [RES_CNT_W-1:0]   cnt_r;
  logic                   pop;

  // room for the worst case of two results from one transaction
  assign room       = cnt_r <= RES_CNT_W'(RES_DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = mem[rd_ptr_r];
  assign pop        = head_valid && !head_stall;
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem[wr_ptr_r + RES_PTR_W'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RES_PTR_W'(push_cnt);
      rd_ptr_r <= rd_ptr_r + RES_PTR_W'(pop);
      cnt_r    <= cnt_r + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
    end
  end

endmodule

// File: design/log_record_stream_checker_top.sv
`timescale 1ns / 1ps

// Write-ahead log checker, one log byte per transaction. Each accepted byte is
// held in an input register and processed from there (header assembly,
// FNV-1a-32 update, field capture, verdict), its results going into a
// four-entry result queue whose head drives the out_ ports, so each result is
// registered in the queue after the input register. Sustained rate is one byte
// per cycle while the queue has room; the input stalls while the queue holds
// more than two results, as the last payload byte of a record with a key or
// value byte pushes two. The configuration port is always ready; the user
// must write registers only while no transaction is in flight (not enforced).
module log_record_stream_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_is_delete,
  output logic [63:0] out_sequence_number,
  output logic [31:0] out_key_length,
  output logic [31:0] out_value_length,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lrsc_pkg::*;

  logic        in_vld_r;
  logic [1:0]  in_cmd_r;
  logic [7:0]  in_byte_r;
  logic        take, room;
  cfg_t        cfg;
  logic [1:0]  push_cnt;
  result_t     push0, push1, head;
  logic [RES_CNT_W-1:0] level;

  assign take     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_data_byte;
    end
  end

  lrsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .cmd       (in_cmd_r),
    .data_byte (in_byte_r),
    .cfg       (cfg),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1)
  );

  lrsc_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (push0),
    .push1      (push1),
    .room       (room),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head       (head),
    .level      (level)
  );

  assign out_kind            = head.kind;
  assign out_out_byte        = head.data;
  assign out_is_delete       = head.is_delete;
  assign out_sequence_number = head.seq;
  assign out_key_length      = head.klen;
  assign out_value_length    = head.vlen;
  assign out_status          = head.status;
  assign out_last            = head.last;

`ifndef NO_ASSERTIONS
  // queue never overflows given the room check on the input side
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> $past(room) || level <= RES_CNT_W'(RES_DEPTH - 2))
    else $error("result queue pushed without room");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue level out of range");

  // verdicts always close the transaction's results
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ACCEPT || out_kind == KIND_STOP) |-> out_last)
    else $error("verdict result not marked last");

  a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STOP |-> out_status != ST_OK)
    else $error("stop result without error status");
`endif

endmodule
